// File: rtl/bfts_pkg.sv
// shared types and constants for the byte fifo with token scan
// no dependencies; imported by bfts_cmp_unit and the top level
package bfts_pkg;

	localparam logic [2:0] KIND_PUT   = 3'd0;
	localparam logic [2:0] KIND_GET   = 3'd1;
	localparam logic [2:0] KIND_PEEK  = 3'd2;
	localparam logic [2:0] KIND_BACK  = 3'd3;
	localparam logic [2:0] KIND_SCAN  = 3'd4;
	localparam logic [2:0] KIND_TOKEN = 3'd5;

	// most bytes one token read may emit
	localparam logic [6:0] TOKEN_CAP = 7'd64;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SCAN_END,
		S_TOK_RD,
		S_TOK_EMIT,
		S_EMIT
	} state_t;

	// sequencer to compare unit
	typedef struct packed {
		logic clr;
		logic inc;
		logic cmp;
	} unit_ctrl_t;

	// compare unit to sequencer
	typedef struct packed {
		logic hit_term;
		logic found;
	} unit_stat_t;

endpackage

// File: rtl/bfts_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module bfts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/bfts_cmp_unit.sv
// shared compare unit: walk index, terminator and stop detection
// depends on bfts_pkg
module bfts_cmp_unit #(
	parameter int PW = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bfts_pkg::unit_ctrl_t ctrl,
	input  logic [7:0]          rdata,
	input  logic [7:0]          db,
	input  logic [6:0]          limit,
	output bfts_pkg::unit_stat_t stat,
	output logic [PW-1:0]       idx,
	output logic [PW-1:0]       stop
);
	import bfts_pkg::*;

	localparam int CW = (PW > 7) ? PW : 7;

	logic [PW-1:0] idx_q;
	logic [PW-1:0] stop_q;
	logic          found_q;
	logic          stop_seen_q;
	logic          hit_term;
	logic          stop_cond;

	assign hit_term  = (rdata == db);
	// a zero byte, the terminator or a byte past the limit ends the token
	assign stop_cond = (rdata == 8'd0) || hit_term || (CW'(idx_q) >= CW'(limit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			stop_q      <= '0;
			found_q     <= 1'b0;
			stop_seen_q <= 1'b0;
		end else if (ctrl.clr) begin
			idx_q       <= '0;
			found_q     <= 1'b0;
			stop_seen_q <= 1'b0;
		end else begin
			if (ctrl.cmp) begin
				if (hit_term) begin
					found_q <= 1'b1;
				end
				if (!stop_seen_q && stop_cond) begin
					stop_seen_q <= 1'b1;
					stop_q      <= idx_q;
				end
			end
			if (ctrl.inc) begin
				idx_q <= idx_q + PW'(1);
			end
		end
	end

	assign stat.hit_term = hit_term;
	assign stat.found    = found_q;
	assign idx           = idx_q;
	assign stop          = stop_q;

endmodule

// File: rtl/byte_fifo_with_token_scan_core.sv
// top level: sequencer, pointers and output register of the byte fifo
// depends on bfts_pkg, bfts_ram and bfts_cmp_unit
//
// usage: one item on the s_axis side is one operation (put, get, peek, back,
// scan or token read, chosen by s_axis_tuser). each item gives one result
// item on the m_axis side, except a token read, which gives one item per
// emitted byte; m_axis_tlast marks the final result of an operation.
// the block takes one operation at a time and drops s_axis_tready until its
// last result is in the output register. put, get, peek and back go straight
// to the result state, as do scan and token read on an empty fifo. otherwise
// scan and token read walk the stored bytes with one ram read port and one
// comparator, a read state and a compare state per byte visited (stopping at
// the first terminator), then an end state; a token read that emits bytes
// then passes each of them through a read state and an emit state in turn.
// results sit in a single output register; when m_axis_tready is low the
// sequencer waits with its next result and no item is lost.
// reset clears both pointers (fifo empty) and the output valid; the byte
// store itself needs no clearing since only written entries are read.
module byte_fifo_with_token_scan_core #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // data_byte[7:0], token_limit[14:8], zero
	input  logic [2:0]  s_axis_tuser,  // kind[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // byte_out[7:0], ok[8], occupancy[15:9],
	                                   // token_length[22:16], zero
	output logic        m_axis_tuser,  // byte_valid
	output logic        m_axis_tlast   // last
);
	import bfts_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int PW = AW + 1;

	state_t state_q, state_d;

	logic [PW-1:0] wp_q, rp_q, base_q, held_q;
	logic [PW-1:0] held;
	logic [2:0]    kind_q;
	logic [7:0]    db_q;
	logic [6:0]    lim_q;
	logic          res_ok_q;
	logic          use_rd_q;

	logic          accept;
	logic          full, empty;
	logic          slot_free;
	logic [7:0]    in_byte;
	logic [6:0]    in_limit;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	unit_ctrl_t    uctrl;
	unit_stat_t    ustat;
	logic [PW-1:0] idx, stop;
	logic          scan_last, tok_last;

	logic          out_load;
	logic [7:0]    nx_byte;
	logic          nx_valid, nx_ok, nx_last;
	logic [6:0]    nx_tlen;

	logic          m_valid_q;
	logic [7:0]    o_byte_q;
	logic          o_valid_q, o_ok_q, o_last_q;
	logic [6:0]    o_occ_q, o_tlen_q;

	assign in_byte   = s_axis_tdata[7:0];
	assign in_limit  = s_axis_tdata[14:8];
	assign held      = wp_q - rp_q;
	assign full      = (held == PW'(DEPTH));
	assign empty     = (held == '0);
	assign accept    = s_axis_tvalid && s_axis_tready;
	assign slot_free = !m_valid_q || m_axis_tready;
	assign scan_last = ((idx + PW'(1)) == held_q);
	assign tok_last  = ((idx + PW'(1)) == stop);

	bfts_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q[AW-1:0]),
		.wdata (in_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bfts_cmp_unit #(
		.PW (PW)
	) u_cmp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (uctrl),
		.rdata  (ram_rdata),
		.db     (db_q),
		.limit  (lim_q),
		.stat   (ustat),
		.idx    (idx),
		.stop   (stop)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if ((s_axis_tuser inside {KIND_SCAN, KIND_TOKEN}) && !empty) begin
						state_d = S_SCAN_RD;
					end else begin
						state_d = S_EMIT;
					end
				end
			end
			S_SCAN_RD: state_d = S_SCAN_CMP;
			S_SCAN_CMP: begin
				if (ustat.hit_term || scan_last) begin
					state_d = S_SCAN_END;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_END: begin
				if (kind_q == KIND_TOKEN && ustat.found && stop != '0) begin
					state_d = S_TOK_RD;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_TOK_RD: state_d = S_TOK_EMIT;
			S_TOK_EMIT: begin
				if (slot_free) begin
					state_d = tok_last ? S_IDLE : S_TOK_RD;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		ram_we        = 1'b0;
		ram_re        = 1'b0;
		ram_raddr     = AW'(base_q + idx);
		uctrl         = '0;
		out_load      = 1'b0;
		nx_byte       = 8'd0;
		nx_valid      = 1'b0;
		nx_ok         = 1'b0;
		nx_last       = 1'b1;
		nx_tlen       = 7'd0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				ram_re        = accept;
				ram_raddr     = rp_q[AW-1:0];
				ram_we        = accept && (s_axis_tuser == KIND_PUT) && !full;
				uctrl.clr     = accept;
			end
			S_SCAN_RD: begin
				ram_re = 1'b1;
			end
			S_SCAN_CMP: begin
				uctrl.cmp = 1'b1;
				uctrl.inc = 1'b1;
			end
			S_SCAN_END: begin
				uctrl.clr = 1'b1;
			end
			S_TOK_RD: begin
				ram_re = 1'b1;
			end
			S_TOK_EMIT: begin
				out_load  = slot_free;
				uctrl.inc = slot_free;
				nx_byte   = ram_rdata;
				nx_valid  = 1'b1;
				nx_last   = tok_last;
				nx_tlen   = tok_last ? 7'(stop) : 7'd0;
			end
			S_EMIT: begin
				out_load = slot_free;
				nx_byte  = use_rd_q ? ram_rdata : 8'd0;
				nx_ok    = res_ok_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wp_q    <= '0;
			rp_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				case (s_axis_tuser)
					KIND_PUT: begin
						if (!full) begin
							wp_q <= wp_q + PW'(1);
						end
					end
					KIND_GET: begin
						if (!empty) begin
							rp_q <= rp_q + PW'(1);
						end
					end
					KIND_BACK: begin
						if (!empty) begin
							wp_q <= wp_q - PW'(1);
						end
					end
					default: ;
				endcase
			end
			// token read drops the emitted bytes and the byte that stopped it
			if (state_q == S_SCAN_END && kind_q == KIND_TOKEN && ustat.found) begin
				rp_q <= rp_q + stop + PW'(1);
			end
		end
	end

	// operation payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= s_axis_tuser;
			db_q     <= in_byte;
			lim_q    <= (in_limit > TOKEN_CAP) ? TOKEN_CAP : in_limit;
			base_q   <= rp_q;
			held_q   <= held;
			case (s_axis_tuser)
				KIND_PUT: begin
					res_ok_q <= !full;
					use_rd_q <= 1'b0;
				end
				KIND_GET, KIND_PEEK: begin
					res_ok_q <= 1'b0;
					use_rd_q <= !empty;
				end
				KIND_BACK: begin
					res_ok_q <= !empty;
					use_rd_q <= 1'b0;
				end
				default: begin
					res_ok_q <= 1'b0;
					use_rd_q <= 1'b0;
				end
			endcase
		end else if (state_q == S_SCAN_END && kind_q == KIND_SCAN) begin
			res_ok_q <= ustat.found;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_byte_q  <= nx_byte;
			o_valid_q <= nx_valid;
			o_ok_q    <= nx_ok;
			o_occ_q   <= 7'(held);
			o_tlen_q  <= nx_tlen;
			o_last_q  <= nx_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, o_tlen_q, o_occ_q, o_ok_q, o_byte_q};
	assign m_axis_tuser  = o_valid_q;
	assign m_axis_tlast  = o_last_q;

endmodule
